// ----- sv/bdar_pkg.sv -----
`default_nettype none

package bdar_pkg;

  localparam int FIELD_W          = 3;
  localparam int NUM_BUTTONS_DEF  = 3;
  localparam int TIME_W           = 32;
  localparam int CFG_W            = 16;
  localparam int ADDR_W           = 4;
  localparam int DATA_W           = 32;

  localparam logic [CFG_W-1:0]   DEBOUNCE_RST = 16'd30;
  localparam logic [CFG_W-1:0]   DELAY_RST    = 16'd500;
  localparam logic [CFG_W-1:0]   INTERVAL_RST = 16'd150;
  localparam logic [FIELD_W-1:0] ENABLE_RST   = 3'd5;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_DELAY    = 2'd1,
    REG_INTERVAL = 2'd2,
    REG_ENABLE   = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_POLL = 1'b0,
    OP_SEED = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] repeat_delay;
    logic [CFG_W-1:0] repeat_interval;
  } timing_t;

endpackage

`default_nettype wire

// ----- sv/bdar_ifs.sv -----
`default_nettype none

interface bdar_item_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [bdar_pkg::TIME_W-1:0]  now_ms;
  logic [bdar_pkg::FIELD_W-1:0] pressed_levels;

  modport source (output valid, opcode, now_ms, pressed_levels, input ready);
  modport sink   (input valid, opcode, now_ms, pressed_levels, output ready);
endinterface

interface bdar_result_if;
  logic                         valid;
  logic                         ready;
  logic [bdar_pkg::FIELD_W-1:0] fire_mask;
  logic [bdar_pkg::FIELD_W-1:0] stable_levels;

  modport source (output valid, fire_mask, stable_levels, input ready);
  modport sink   (input valid, fire_mask, stable_levels, output ready);
endinterface

`default_nettype wire

// ----- sv/bdar_button.sv -----
`default_nettype none

module bdar_button (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        seed,
  input  wire logic [bdar_pkg::TIME_W-1:0] now_ms,
  input  wire logic                        lvl,
  input  wire logic                        rep_en,
  input  wire bdar_pkg::timing_t           timing,
  output logic                             fire,
  output logic                             stable_next
);
  import bdar_pkg::*;

  logic              raw, raw_next;
  logic              stable;
  logic              armed, armed_next;
  logic              repeating, repeating_next;
  logic [TIME_W-1:0] edge_time, edge_time_next;
  logic [TIME_W-1:0] press_time, press_time_next;
  logic [TIME_W-1:0] rep_time, rep_time_next;

  logic [TIME_W-1:0] since_edge, since_press, since_rep;

  assign since_edge  = now_ms - edge_time;
  assign since_press = now_ms - press_time;
  assign since_rep   = now_ms - rep_time;

  always_comb begin
    raw_next        = raw;
    stable_next     = stable;
    armed_next      = armed;
    repeating_next  = repeating;
    edge_time_next  = edge_time;
    press_time_next = press_time;
    rep_time_next   = rep_time;
    fire            = 1'b0;
    if (seed) begin
      raw_next       = lvl;
      stable_next    = lvl;
      armed_next     = 1'b0;
      edge_time_next = now_ms;
    end else if (lvl != raw) begin
      raw_next       = lvl;
      edge_time_next = now_ms;
    end else if (since_edge < {{(TIME_W-CFG_W){1'b0}}, timing.debounce_time}) begin
      // still settling
    end else if (lvl != stable) begin
      stable_next = lvl;
      if (lvl) begin
        armed_next      = 1'b1;
        press_time_next = now_ms;
        repeating_next  = 1'b0;
        fire            = 1'b1;
      end else begin
        armed_next = 1'b0;
      end
    end else if (stable && rep_en && armed) begin
      if (!repeating) begin
        if (since_press >= {{(TIME_W-CFG_W){1'b0}}, timing.repeat_delay}) begin
          repeating_next = 1'b1;
          rep_time_next  = now_ms;
          fire           = 1'b1;
        end
      end else if (since_rep >= {{(TIME_W-CFG_W){1'b0}}, timing.repeat_interval}) begin
        rep_time_next = now_ms;
        fire          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw        <= 1'b0;
      stable     <= 1'b0;
      armed      <= 1'b0;
      repeating  <= 1'b0;
      edge_time  <= '0;
      press_time <= '0;
      rep_time   <= '0;
    end else if (en) begin
      raw        <= raw_next;
      stable     <= stable_next;
      armed      <= armed_next;
      repeating  <= repeating_next;
      edge_time  <= edge_time_next;
      press_time <= press_time_next;
      rep_time   <= rep_time_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/button_debounce_auto_repeat_unit.sv -----
// Button debounce with auto-repeat.
// items (sink): one transaction per poll tick or seed; opcode selects seed,
//   now_ms is the millisecond timestamp (wraps), pressed_levels one bit per
//   button, 1 meaning pressed.
// results (source): exactly one transaction per item, with fire_mask (buttons
//   that fired on this item) and stable_levels (debounced state after it).
// APB port: four 16/3-bit registers at byte offsets 0, 4, 8, 12: debounce
//   time, repeat delay, repeat interval, repeat enable mask. pready is always
//   high; write only while the block is idle.
// Timing: an item is captured in an input register, then the per-button
//   compare logic updates the button state and loads the result register
//   when the item advances out of the input register, raising results.valid.
//   One item per cycle is sustained while results.ready is high; each
//   button's update is three 32-bit subtracts and compares, combinational.
// Stall: a waiting result does not block the input register, which holds a
//   second item; items.ready drops only with both full and results.ready low.
// Reset: all button state, timestamps and pipeline valids clear and the
//   registers return to 30, 500, 150 and mask 5.
`default_nettype none

module button_debounce_auto_repeat_unit #(
  parameter int unsigned NUM_BUTTONS = bdar_pkg::NUM_BUTTONS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  bdar_item_if.sink                        items,
  bdar_result_if.source                    results,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bdar_pkg::ADDR_W-1:0] paddr,
  input  wire logic [bdar_pkg::DATA_W-1:0] pwdata,
  output logic      [bdar_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  import bdar_pkg::*;

  timing_t            timing;
  logic [FIELD_W-1:0] enable_mask;
  reg_idx_t           reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      timing.debounce_time   <= DEBOUNCE_RST;
      timing.repeat_delay    <= DELAY_RST;
      timing.repeat_interval <= INTERVAL_RST;
      enable_mask            <= ENABLE_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_DEBOUNCE: timing.debounce_time   <= pwdata[CFG_W-1:0];
        REG_DELAY:    timing.repeat_delay    <= pwdata[CFG_W-1:0];
        REG_INTERVAL: timing.repeat_interval <= pwdata[CFG_W-1:0];
        REG_ENABLE:   enable_mask            <= pwdata[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE: prdata = {{(DATA_W-CFG_W){1'b0}}, timing.debounce_time};
      REG_DELAY:    prdata = {{(DATA_W-CFG_W){1'b0}}, timing.repeat_delay};
      REG_INTERVAL: prdata = {{(DATA_W-CFG_W){1'b0}}, timing.repeat_interval};
      REG_ENABLE:   prdata = {{(DATA_W-FIELD_W){1'b0}}, enable_mask};
      default:      prdata = '0;
    endcase
  end

  // input stage
  logic               s1_valid;
  logic               s1_seed;
  logic [TIME_W-1:0]  s1_now;
  logic [FIELD_W-1:0] s1_levels;
  logic               advance;

  // result stage
  logic               out_valid;
  logic [FIELD_W-1:0] fire_q;
  logic [FIELD_W-1:0] stable_q;

  assign advance     = s1_valid && (!out_valid || results.ready);
  assign items.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      s1_seed   <= (items.opcode == OP_SEED);
      s1_now    <= items.now_ms;
      s1_levels <= items.pressed_levels;
    end
  end

  logic [NUM_BUTTONS-1:0] fire;
  logic [NUM_BUTTONS-1:0] stable_next;
  logic [FIELD_W-1:0]     fire_field;
  logic [FIELD_W-1:0]     stable_field;

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
    logic lvl;
    logic rep_en;
    if (i < FIELD_W) begin : g_in
      assign lvl    = s1_levels[i];
      assign rep_en = enable_mask[i];
    end else begin : g_extra
      assign lvl    = 1'b0;
      assign rep_en = 1'b0;
    end
    bdar_button u_btn (
      .clk         (clk),
      .rst         (rst),
      .en          (advance),
      .seed        (s1_seed),
      .now_ms      (s1_now),
      .lvl         (lvl),
      .rep_en      (rep_en),
      .timing      (timing),
      .fire        (fire[i]),
      .stable_next (stable_next[i])
    );
  end

  for (genvar b = 0; b < FIELD_W; b++) begin : g_field
    if (b < NUM_BUTTONS) begin : g_on
      assign fire_field[b]   = fire[b];
      assign stable_field[b] = stable_next[b];
    end else begin : g_off
      assign fire_field[b]   = 1'b0;
      assign stable_field[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fire_q   <= fire_field;
      stable_q <= stable_field;
    end
  end

  assign results.valid         = out_valid;
  assign results.fire_mask     = fire_q;
  assign results.stable_levels = stable_q;

endmodule

`default_nettype wire
